/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the stencil RTL.
// Each macro samples on the rising edge of clk and is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lgs_pkg.sv */
// ---------------------------------------------------------------------------
// lgs_pkg
// Types, constants and the Life rule shared by the stencil RTL.
// ---------------------------------------------------------------------------
package lgs_pkg;

	// Field and register widths.
	localparam int ROW_W = 12;
	localparam int COL_W = 9;
	localparam int GC_W  = 10;
	localparam int CFG_W = 12;

	// Register reset values.
	localparam logic [GC_W-1:0]  GRID_COLUMNS_RST = 10'd500;
	localparam logic [ROW_W-1:0] GRID_ROWS_RST    = 12'd500;

	// Smallest legal grid edge.
	localparam int MIN_EDGE = 3;

	// Life rule: born on three, survives on two or three.
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Configuration register indexes.
	typedef enum logic {
		CFG_GRID_COLUMNS = 1'b0,
		CFG_GRID_ROWS    = 1'b1
	} cfg_reg_t;

	// One queue entry: one or two results of the same input item.
	typedef struct packed {
		logic             alive0;
		logic             alive1;
		logic             pair;
		logic             done;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} res_pair_t;

	// Next state of the center cell of a 3x3 window (bit 4 is the center).
	function automatic logic life_next(input logic [8:0] w);
		logic [3:0] n;
		n = 4'(w[0]) + 4'(w[1]) + 4'(w[2]) + 4'(w[3])
			+ 4'(w[5]) + 4'(w[6]) + 4'(w[7]) + 4'(w[8]);
		return w[4] ? (n == SURVIVE_COUNT || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
	endfunction

endpackage

/* src/lgs_if.sv */
// ---------------------------------------------------------------------------
// lgs_if
// Valid/ready channels of the stencil: the cell stream and the result stream.
// ---------------------------------------------------------------------------

// Cell stream: one beat per raster cell or flush item.
interface lgs_cell_if;
	logic valid;
	logic ready;
	logic kind;
	logic cell_alive;

	modport source (output valid, output kind, output cell_alive, input ready);
	modport sink   (input valid, input kind, input cell_alive, output ready);
endinterface

// Result stream: one beat per next-generation cell.
interface lgs_result_if import lgs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             next_alive;
	logic [ROW_W-1:0] cell_row;
	logic [COL_W-1:0] cell_column;
	logic             frame_done;

	modport source (output valid, output next_alive, output cell_row,
		output cell_column, output frame_done, input ready);
	modport sink   (input valid, input next_alive, input cell_row,
		input cell_column, input frame_done, output ready);
endinterface

/* src/lgs_result_fifo.sv */
// ---------------------------------------------------------------------------
// lgs_result_fifo
// Small result queue. Each entry holds the one or two results of one input
// item and is sent as one or two beats on the result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lgs_result_fifo import lgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  res_pair_t         push_data,
	lgs_result_if.source      results,
	output logic [QCNT_W-1:0] level
);

	res_pair_t          entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               sub_q;
	res_pair_t          head;
	logic               beat;
	logic               pop;

	// Head entry and which of its two results is on the channel.
	assign head = entry_q[rd_ptr_q];
	assign beat = results.valid && results.ready;
	assign pop  = beat && (!head.pair || sub_q);

	assign results.valid       = (cnt_q != '0);
	assign results.next_alive  = sub_q ? head.alive1 : head.alive0;
	assign results.cell_row    = head.row;
	assign results.cell_column = head.col + COL_W'(sub_q);
	assign results.frame_done  = sub_q && head.done;
	assign level               = cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers, fill count and the second-beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (pop) begin
				sub_q <= 1'b0;
			end else if (beat) begin
				sub_q <= 1'b1;
			end
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, push && !pop, cnt_q != QCNT_W'(QDEPTH), "result queue overflow")
	`ASSERT_IMPLIES(a_sub_on_pair, sub_q, results.valid && head.pair, "second beat without a pair")
	`ASSERT_NEXT(a_hold_on_stall, results.valid && !results.ready, results.valid, "stalled beat lost")

endmodule

/* src/life_generation_stencil.sv */
// ---------------------------------------------------------------------------
// life_generation_stencil
// One Conway Life generation (B3/S23) over a raster streamed row by row.
// Usage: send grid_rows rows of grid_columns beats on "cells" (kind 0 with
// the cell state), then one row of flush beats (kind 1). Each beat at stream
// row r >= 1, column c >= 1 yields the next state of cell (r-1, c-1) on
// "results"; the last column beat also yields cell (r-1, last). frame_done
// marks the result for the final grid cell.
// Throughput: one cell beat per cycle while the result queue has room; the
// single line memory is read at accept and written back in the next cycle,
// so no beat waits on another. Results pass stage 1 and the result queue.
// When the receiver stalls, results wait in a four-entry queue; cells are
// refused once the queue cannot take the beat in flight plus one more.
// Reset clears the counters and window, sets both geometry registers to
// 500 and needs no clearing pass: line memory is masked until written.
// Write configuration only while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module life_generation_stencil import lgs_pkg::*; #(
	parameter int MAX_COLUMNS = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	lgs_cell_if.sink         cells,
	lgs_result_if.source     results
);

	localparam int AW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
	localparam int NW = $clog2(MAX_COLUMNS + 1);
	localparam int XW = 13;

	// Configuration registers.
	logic [GC_W-1:0]  grid_columns_q;
	logic [ROW_W-1:0] grid_rows_q;

	// Raster position of the next beat.
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// Stage 1: beat whose line memory entry is being read.
	logic             v_s1;
	logic [AW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             cur_s1;
	logic             last_s1;
	logic             done_s1;
	logic             up_en_s1;
	logic             mid_en_s1;
	logic             fwd_s1;
	logic [1:0]       fwd_data_s1;
	logic [1:0]       rd_s1;

	// Line memory: bit 1 is the upper line, bit 0 the middle line.
	logic [1:0] line_mem [MAX_COLUMNS];

	logic [8:0] window_q;

	logic [XW-1:0]     ncol_x;
	logic [NW-1:0]     ncol;
	logic [ROW_W-1:0]  nrow;
	logic              accept;
	logic              wrap;
	logic [AW-1:0]     c0;
	logic [XW-1:0]     row_t;
	logic [ROW_W-1:0]  r0;
	logic [XW-1:0]     row_n;
	logic [NW-1:0]     col_n;
	logic              last0;
	logic              cur0;
	logic [1:0]        entry;
	logic              up;
	logic              mid;
	logic [8:0]        win_base;
	logic [8:0]        win1;
	logic [8:0]        win2;
	logic              push;
	res_pair_t         push_data;
	logic [QCNT_W-1:0] level;

	// Geometry in use, clamped to the legal range.
	always_comb begin
		ncol_x = XW'(grid_columns_q);
		if (ncol_x < XW'(MIN_EDGE)) begin
			ncol_x = XW'(MIN_EDGE);
		end else if (ncol_x > XW'(MAX_COLUMNS)) begin
			ncol_x = XW'(MAX_COLUMNS);
		end
		ncol = ncol_x[NW-1:0];
		nrow = (grid_rows_q < ROW_W'(MIN_EDGE)) ? ROW_W'(MIN_EDGE) : grid_rows_q;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_COLUMNS_RST;
			grid_rows_q    <= GRID_ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_data[GC_W-1:0];
				CFG_GRID_ROWS:    grid_rows_q    <= cfg_data[ROW_W-1:0];
				default:          ;
			endcase
		end
	end

	// Accept a beat only if the queue can hold it and the one in flight.
	assign cells.ready = (QCNT_W'(level + QCNT_W'(v_s1)) < QCNT_W'(QDEPTH));
	assign accept      = cells.valid && cells.ready;

	// Position of the incoming beat; a stale column ends the row first.
	always_comb begin
		wrap  = (NW'(col_q) >= ncol);
		c0    = wrap ? '0 : col_q;
		row_t = XW'(row_q) + XW'(wrap);
		r0    = (row_t > XW'(nrow)) ? '0 : row_t[ROW_W-1:0];
		col_n = NW'(c0) + 1'b1;
		last0 = (col_n == ncol);
		row_n = XW'(r0) + 1'b1;
		cur0  = (r0 < nrow) && !cells.kind && cells.cell_alive;
	end

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last0) begin
				col_q <= '0;
				row_q <= (row_n > XW'(nrow)) ? '0 : row_n[ROW_W-1:0];
			end else begin
				col_q <= col_n[AW-1:0];
				row_q <= r0;
			end
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Stage 1 payload, with forwarding when the entry is still being written.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= c0;
			row_s1      <= r0;
			cur_s1      <= cur0;
			last_s1     <= last0;
			done_s1     <= (r0 == nrow);
			up_en_s1    <= (r0 >= ROW_W'(2));
			mid_en_s1   <= (r0 != '0);
			fwd_s1      <= v_s1 && (col_s1 == c0);
			fwd_data_s1 <= {mid, cur_s1};
		end
	end

	// Line memory read port.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[c0];
		end
	end

	// Line memory write-back: the middle line moves up, the new cell enters.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[col_s1] <= {mid, cur_s1};
		end
	end

	// Window update and rule evaluation; rows above the grid read as dead.
	always_comb begin
		entry    = fwd_s1 ? fwd_data_s1 : rd_s1;
		up       = up_en_s1 && entry[1];
		mid      = mid_en_s1 && entry[0];
		win_base = (col_s1 == '0) ? '0 : window_q;
		win1     = {cur_s1, mid, up, win_base[8:3]};
		win2     = {3'b000, win1[8:3]};
	end

	// Sliding window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (v_s1) begin
			window_q <= last_s1 ? win2 : win1;
		end
	end

	// Results for the cell one row up and one column left.
	always_comb begin
		push             = v_s1 && (row_s1 != '0) && (col_s1 != '0);
		push_data.alive0 = life_next(win1);
		push_data.alive1 = life_next(win2);
		push_data.pair   = last_s1;
		push_data.done   = last_s1 && done_s1;
		push_data.row    = row_s1 - 1'b1;
		push_data.col    = COL_W'(col_s1 - 1'b1);
	end

	lgs_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.results   (results),
		.level     (level)
	);

	`ASSERT_NEXT(a_accept_loads_s1, accept, v_s1, "accepted beat did not reach stage 1")
	`ASSERT_IMPLIES(a_room_for_s1, v_s1, level != QCNT_W'(QDEPTH), "no queue room for beat in flight")
	`ASSERT_IMPLIES(a_fwd_adjacent, accept && v_s1, col_s1 != c0, "back-to-back beats on one column")

endmodule
